// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and arithmetic helpers for barometric compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int DIV_W = 32;

	typedef enum logic [1:0] {
		CFG_WORD_A = 2'd0,
		CFG_WORD_B = 2'd1,
		CFG_WORD_C = 2'd2,
		CFG_OSS    = 2'd3
	} cfg_idx_t;

	localparam logic [31:0] T_OFFSET   = 32'd4000;
	localparam logic [31:0] B4_BIAS    = 32'd32768;
	localparam logic [31:0] B7_SCALE   = 32'd50000;
	localparam logic [31:0] C_SQ       = 32'd3038;
	localparam logic [31:0] C_LIN      = 32'hFFFF_E343; // -7357
	localparam logic [31:0] C_OFS      = 32'd3791;
	localparam logic [32:0] TEN_RECIP  = 33'd52429;
	localparam int          TEN_SHIFT  = 19;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return a * b;
	endfunction

	// signed divide by 2**sh, truncating toward zero
	function automatic logic [31:0] sdiv_pow2(input logic [31:0] x, input logic [4:0] sh);
		logic [31:0] mask;
		logic [31:0] bias;
		mask = (32'd1 << sh) - 32'd1;
		bias = x[31] ? mask : 32'd0;
		return $unsigned($signed(x + bias) >>> sh);
	endfunction

endpackage

// ===== rtl/bsc_udiv.sv =====
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_udiv #(
	parameter int N  = bsc_pkg::DIV_W,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [N-1:0]  dividend,
	input  logic [N-1:0]  divisor,
	input  logic [PW-1:0] payload,
	output logic          out_valid,
	output logic [N-1:0]  quotient,
	output logic [PW-1:0] out_payload
);

	logic [N-1:0]  rem_s [N];
	logic [N-1:0]  dq_s  [N];
	logic [N-1:0]  dv_s  [N];
	logic [PW-1:0] pl_s  [N];
	logic [N-1:0]  vld_s;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N-1:0]  rem_i;
		logic [N-1:0]  dq_i;
		logic [N-1:0]  dv_i;
		logic [PW-1:0] pl_i;
		logic          v_i;
		logic [N:0]    trial;
		logic [N:0]    diff;
		logic          fit;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign dq_i  = dividend;
			assign dv_i  = divisor;
			assign pl_i  = payload;
			assign v_i   = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign dq_i  = dq_s[k-1];
			assign dv_i  = dv_s[k-1];
			assign pl_i  = pl_s[k-1];
			assign v_i   = vld_s[k-1];
		end

		assign trial = {rem_i, dq_i[N-1]};
		assign diff  = trial - {1'b0, dv_i};
		assign fit   = trial >= {1'b0, dv_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fit ? diff[N-1:0] : trial[N-1:0];
				dq_s[k]  <= {dq_i[N-2:0], fit};
				dv_s[k]  <= dv_i;
				pl_s[k]  <= pl_i;
			end
		end
	end

	assign out_valid   = vld_s[N-1];
	assign quotient    = dq_s[N-1];
	assign out_payload = pl_s[N-1];

endmodule

// ===== rtl/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer pressure and temperature compensation from packed calibration.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | raw_temp, raw_pressure
//  out     | output    | out_valid / out_stall | pressure_pa, temp_tenths,
//          |           |                       | temp_degrees, div_error
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat per cycle in while out is not held; two 32-stage dividers (x2 and p)
// plus 14 arithmetic stages, at most one multiplier level per stage
// the whole pipeline holds while a result sits on out with out_stall high
// reset clears valid bits and calibration registers; cfg_ready is always high
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] raw_temp,
	input  logic [18:0] raw_pressure,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pressure_pa,
	output logic [15:0] temp_tenths,
	output logic [12:0] temp_degrees,
	output logic        div_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int N = bsc_pkg::DIV_W;

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (bsc_pkg::cfg_idx_t'(cfg_index))
				bsc_pkg::CFG_WORD_A: cal_a_q <= cfg_data;
				bsc_pkg::CFG_WORD_B: cal_b_q <= cfg_data;
				bsc_pkg::CFG_WORD_C: cal_c_q <= cfg_data[31:0];
				bsc_pkg::CFG_OSS:    oss_q   <= cfg_data[1:0];
				default:             oss_q   <= oss_q;
			endcase
		end
	end

	assign ac1 = bsc_pkg::sx16(cal_a_q[15:0]);
	assign ac2 = bsc_pkg::sx16(cal_a_q[31:16]);
	assign ac3 = bsc_pkg::sx16(cal_a_q[47:32]);
	assign ac4 = {16'd0, cal_a_q[63:48]};
	assign ac5 = {16'd0, cal_b_q[15:0]};
	assign ac6 = {16'd0, cal_b_q[31:16]};
	assign b1  = bsc_pkg::sx16(cal_b_q[47:32]);
	assign b2  = bsc_pkg::sx16(cal_b_q[63:48]);
	assign mc  = bsc_pkg::sx16(cal_c_q[15:0]);
	assign md  = bsc_pkg::sx16(cal_c_q[31:16]);

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: temperature product
	logic        v_s1;
	logic [31:0] prod_t_s1;
	logic [18:0] up_s1;

	// stage 2: x1, x3 and divider operands
	logic        v_s2;
	logic [31:0] x1_s2, num_s2, den_s2;
	logic [18:0] up_s2;
	logic        zero_s2, sign_s2;
	logic [31:0] x1_c2, x3_c2, num_c2;

	// divider 1
	logic        d1_v;
	logic [N-1:0] d1_q;
	logic [52:0] d1_pl;

	// stage 3
	logic        v_s3;
	logic [31:0] b5_s3;
	logic [18:0] up_s3;
	logic        zero_s3;

	// stage 4
	logic        v_s4;
	logic [15:0] tt_s4;
	logic [31:0] msq_s4, mac2_s4, mac3_s4;
	logic [18:0] up_s4;
	logic        zero_s4;
	logic [31:0] t_c4, b6_c4;

	// stage 5
	logic        v_s5;
	logic [31:0] sq_s5, x2a_s5, x1b_s5;
	logic [15:0] tt_s5;
	logic [32:0] degm_s5;
	logic        tneg_s5;
	logic [18:0] up_s5;
	logic        zero_s5;
	logic [16:0] tabs_c5;

	// stage 6
	logic        v_s6;
	logic [31:0] mb2_s6, mb1_s6, x2a_s6, x1b_s6;
	logic [15:0] tt_s6;
	logic [12:0] deg_s6;
	logic [18:0] up_s6;
	logic        zero_s6;
	logic [12:0] dq_c6;

	// stage 7
	logic        v_s7;
	logic [31:0] x3a_s7, x3bp_s7;
	logic [15:0] tt_s7;
	logic [12:0] deg_s7;
	logic [18:0] up_s7;
	logic        zero_s7;

	// stage 8
	logic        v_s8;
	logic [31:0] b3_s8, x3b_s8;
	logic [15:0] tt_s8;
	logic [12:0] deg_s8;
	logic [18:0] up_s8;
	logic        zero_s8;
	logic [31:0] t_c8;

	// stage 9
	logic        v_s9;
	logic [31:0] b4p_s9, diff_s9;
	logic [15:0] tt_s9;
	logic [12:0] deg_s9;
	logic        zero_s9;

	// stage 10
	logic        v_s10;
	logic [31:0] b4_s10, b7_s10;
	logic [15:0] tt_s10;
	logic [12:0] deg_s10;
	logic        err_s10;

	// divider 2
	logic        d2_v;
	logic [N-1:0] d2_q;
	logic [30:0] d2_pl;
	logic        big_c10;
	logic [31:0] dvd_c10;

	// stage 12
	logic        v_s12;
	logic [31:0] p_s12, msq_s12, m7_s12;
	logic [15:0] tt_s12;
	logic [12:0] deg_s12;
	logic        err_s12;
	logic [31:0] pu_c12, p256_c12;

	// stage 13
	logic        v_s13;
	logic [31:0] p_s13, m38_s13, x2_s13;
	logic [15:0] tt_s13;
	logic [12:0] deg_s13;
	logic        err_s13;

	// stage 14
	logic        v_s14;
	logic [31:0] p_s14, sum_s14;
	logic [15:0] tt_s14;
	logic [12:0] deg_s14;
	logic        err_s14;

	// stage 15: output register
	logic        v_s15;
	logic [31:0] p_s15;
	logic [15:0] tt_s15;
	logic [12:0] deg_s15;
	logic        err_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= d1_v;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s12 <= d2_v;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			prod_t_s1 <= bsc_pkg::mul32({16'd0, raw_temp} - ac6, ac5);
			up_s1     <= raw_pressure;
		end
	end

	// stage 2
	always_comb begin
		x1_c2  = bsc_pkg::sdiv_pow2(prod_t_s1, 5'd15);
		x3_c2  = x1_c2 + md;
		num_c2 = mc << 11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2   <= x1_c2;
			up_s2   <= up_s1;
			zero_s2 <= (x3_c2 == 32'd0);
			sign_s2 <= num_c2[31] ^ x3_c2[31];
			num_s2  <= num_c2[31] ? (32'd0 - num_c2) : num_c2;
			den_s2  <= x3_c2[31] ? (32'd0 - x3_c2) : x3_c2;
		end
	end

	bsc_udiv #(.N(N), .PW(53)) u_div_temp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s2),
		.dividend   (num_s2),
		.divisor    (den_s2),
		.payload    ({x1_s2, up_s2, zero_s2, sign_s2}),
		.out_valid  (d1_v),
		.quotient   (d1_q),
		.out_payload(d1_pl)
	);

	// stage 3: b5
	always_ff @(posedge clk) begin
		if (en) begin
			b5_s3   <= d1_pl[52:21] + (d1_pl[0] ? (32'd0 - d1_q) : d1_q);
			up_s3   <= d1_pl[20:2];
			zero_s3 <= d1_pl[1];
		end
	end

	// stage 4: temperature tenths, b6 products
	always_comb begin
		t_c4  = bsc_pkg::sdiv_pow2(b5_s3 + 32'd8, 5'd4);
		b6_c4 = b5_s3 - bsc_pkg::T_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if ($signed(t_c4) > 32'sd32767) begin
				tt_s4 <= 16'h7FFF;
			end else if ($signed(t_c4) < -32'sd32768) begin
				tt_s4 <= 16'h8000;
			end else begin
				tt_s4 <= t_c4[15:0];
			end
			msq_s4  <= bsc_pkg::mul32(b6_c4, b6_c4);
			mac2_s4 <= bsc_pkg::mul32(ac2, b6_c4);
			mac3_s4 <= bsc_pkg::mul32(ac3, b6_c4);
			up_s4   <= up_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5
	assign tabs_c5 = tt_s4[15] ? (17'd0 - {1'b1, tt_s4}) : {1'b0, tt_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5   <= bsc_pkg::sdiv_pow2(msq_s4, 5'd12);
			x2a_s5  <= bsc_pkg::sdiv_pow2(mac2_s4, 5'd11);
			x1b_s5  <= bsc_pkg::sdiv_pow2(mac3_s4, 5'd13);
			tt_s5   <= tt_s4;
			degm_s5 <= {16'd0, tabs_c5} * bsc_pkg::TEN_RECIP;
			tneg_s5 <= tt_s4[15];
			up_s5   <= up_s4;
			zero_s5 <= zero_s4;
		end
	end

	// stage 6
	assign dq_c6 = degm_s5[bsc_pkg::TEN_SHIFT +: 13];

	always_ff @(posedge clk) begin
		if (en) begin
			mb2_s6  <= bsc_pkg::mul32(b2, sq_s5);
			mb1_s6  <= bsc_pkg::mul32(b1, sq_s5);
			x2a_s6  <= x2a_s5;
			x1b_s6  <= x1b_s5;
			deg_s6  <= tneg_s5 ? (13'd0 - dq_c6) : dq_c6;
			tt_s6   <= tt_s5;
			up_s6   <= up_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stage 7
	always_ff @(posedge clk) begin
		if (en) begin
			x3a_s7  <= bsc_pkg::sdiv_pow2(mb2_s6, 5'd11) + x2a_s6;
			x3bp_s7 <= x1b_s6 + bsc_pkg::sdiv_pow2(mb1_s6, 5'd16) + 32'd2;
			tt_s7   <= tt_s6;
			deg_s7  <= deg_s6;
			up_s7   <= up_s6;
			zero_s7 <= zero_s6;
		end
	end

	// stage 8: b3
	assign t_c8 = ((ac1 << 2) + x3a_s7) << oss_q;

	always_ff @(posedge clk) begin
		if (en) begin
			b3_s8   <= bsc_pkg::sdiv_pow2(t_c8 + 32'd2, 5'd2);
			x3b_s8  <= bsc_pkg::sdiv_pow2(x3bp_s7, 5'd2);
			tt_s8   <= tt_s7;
			deg_s8  <= deg_s7;
			up_s8   <= up_s7;
			zero_s8 <= zero_s7;
		end
	end

	// stage 9
	always_ff @(posedge clk) begin
		if (en) begin
			b4p_s9  <= bsc_pkg::mul32(ac4, x3b_s8 + bsc_pkg::B4_BIAS);
			diff_s9 <= {13'd0, up_s8} - b3_s8;
			tt_s9   <= tt_s8;
			deg_s9  <= deg_s8;
			zero_s9 <= zero_s8;
		end
	end

	// stage 10: b4, b7
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s10  <= b4p_s9 >> 15;
			b7_s10  <= bsc_pkg::mul32(diff_s9, bsc_pkg::B7_SCALE >> oss_q);
			err_s10 <= zero_s9 || (b4p_s9[31:15] == 17'd0);
			tt_s10  <= tt_s9;
			deg_s10 <= deg_s9;
		end
	end

	assign big_c10 = b7_s10[31];
	assign dvd_c10 = big_c10 ? b7_s10 : (b7_s10 << 1);

	bsc_udiv #(.N(N), .PW(31)) u_div_press (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s10),
		.dividend   (dvd_c10),
		.divisor    (b4_s10),
		.payload    ({tt_s10, deg_s10, err_s10, big_c10}),
		.out_valid  (d2_v),
		.quotient   (d2_q),
		.out_payload(d2_pl)
	);

	// stage 12
	always_comb begin
		pu_c12   = d2_pl[0] ? (d2_q << 1) : d2_q;
		p256_c12 = bsc_pkg::sdiv_pow2(pu_c12, 5'd8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s12   <= pu_c12;
			msq_s12 <= bsc_pkg::mul32(p256_c12, p256_c12);
			m7_s12  <= bsc_pkg::mul32(bsc_pkg::C_LIN, pu_c12);
			tt_s12  <= d2_pl[30:15];
			deg_s12 <= d2_pl[14:2];
			err_s12 <= d2_pl[1];
		end
	end

	// stage 13
	always_ff @(posedge clk) begin
		if (en) begin
			m38_s13 <= bsc_pkg::mul32(msq_s12, bsc_pkg::C_SQ);
			x2_s13  <= bsc_pkg::sdiv_pow2(m7_s12, 5'd16);
			p_s13   <= p_s12;
			tt_s13  <= tt_s12;
			deg_s13 <= deg_s12;
			err_s13 <= err_s12;
		end
	end

	// stage 14
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s14 <= bsc_pkg::sdiv_pow2(m38_s13, 5'd16) + x2_s13 + bsc_pkg::C_OFS;
			p_s14   <= p_s13;
			tt_s14  <= tt_s13;
			deg_s14 <= deg_s13;
			err_s14 <= err_s13;
		end
	end

	// stage 15
	always_ff @(posedge clk) begin
		if (en) begin
			p_s15   <= err_s14 ? 32'd0 : (p_s14 + bsc_pkg::sdiv_pow2(sum_s14, 5'd4));
			tt_s15  <= err_s14 ? 16'd0 : tt_s14;
			deg_s15 <= err_s14 ? 13'd0 : deg_s14;
			err_s15 <= err_s14;
		end
	end

	assign out_valid    = v_s15;
	assign pressure_pa  = p_s15;
	assign temp_tenths  = tt_s15;
	assign temp_degrees = deg_s15;
	assign div_error    = err_s15;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |->
			pressure_pa == 32'd0 && temp_tenths == 16'd0 && temp_degrees == 13'd0)
		else $error("error beat carries nonzero results");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa) && $stable(temp_tenths))
		else $error("stalled result beat changed");

	a_deg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !temp_tenths[15] |-> !temp_degrees[12])
		else $error("degrees sign disagrees with tenths");

	a_div_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(d2_q) && $stable(d2_v))
		else $error("divider advanced while pipeline held");

endmodule

// ===== tb/tb_baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation
// Self-checking bench: drives raw readings under several calibration sets,
// predicts each compensated result and compares it with the block's output.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] pressure;
		logic [15:0] tenths;
		logic [12:0] degrees;
		logic        err;
	} comp_result_t;

	class comp_scoreboard;
		logic [63:0] word_a, word_b, word_c;
		logic [1:0]  oss;
		comp_result_t pending[$];
		int errors;

		function int s16(logic [15:0] v);
			return $signed(v);
		endfunction

		function int qdiv(int a, int b);
			longint q;
			q = longint'(a) / longint'(b);
			return int'(q[31:0]);
		endfunction

		function comp_result_t compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
			comp_result_t r;
			int ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
			int x1, x2, x3, b3, b5, b6, sq, tt, p;
			int unsigned ac4, b4, b7, pu, up;
			ac1 = s16(word_a[15:0]); ac2 = s16(word_a[31:16]);
			ac3 = s16(word_a[47:32]); ac4 = 32'(word_a[63:48]);
			ac5 = 32'(word_b[15:0]); ac6 = 32'(word_b[31:16]);
			b1 = s16(word_b[47:32]); b2 = s16(word_b[63:48]);
			mc = s16(word_c[15:0]); md = s16(word_c[31:16]);
			ut = 32'(ut_raw); up = 32'(up_raw);
			r = '0;
			r.err = 1'b1;
			x1 = qdiv((ut - ac6) * ac5, 32768);
			x3 = x1 + md;
			if (x3 == 0)
				return r;
			x2 = qdiv(mc * 2048, x3);
			b5 = x1 + x2;
			tt = qdiv(b5 + 8, 16);
			if (tt > 32767) tt = 32767;
			if (tt < -32768) tt = -32768;
			b6 = b5 - 4000;
			sq = qdiv(b6 * b6, 4096);
			x1 = qdiv(b2 * sq, 2048);
			x2 = qdiv(ac2 * b6, 2048);
			x3 = x1 + x2;
			b3 = qdiv(((ac1 * 4 + x3) << oss) + 2, 4);
			x1 = qdiv(ac3 * b6, 8192);
			x2 = qdiv(b1 * sq, 65536);
			x3 = qdiv(x1 + x2 + 2, 4);
			b4 = (ac4 * (int'(x3) + 32768)) / 32'd32768;
			if (b4 == 0)
				return r;
			b7 = (up - b3) * (32'd50000 >> oss);
			if (b7 < 32'h8000_0000)
				pu = (b7 * 2) / b4;
			else
				pu = (b7 / b4) * 2;
			p = pu;
			x1 = qdiv(p, 256) * qdiv(p, 256);
			x1 = qdiv(x1 * 3038, 65536);
			x2 = qdiv(-7357 * p, 65536);
			p = p + qdiv(x1 + x2 + 3791, 16);
			r.pressure = p;
			r.tenths = tt[15:0];
			r.degrees = 13'(tt / 10);
			r.err = 1'b0;
			return r;
		endfunction

		function void note_reading(logic [15:0] ut, logic [18:0] up);
			pending.push_back(compensate(ut, up));
		endfunction

		function void check_result(comp_result_t got);
			comp_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp p=%0d t=%0d d=%0d e=%0b got p=%0d t=%0d d=%0d e=%0b",
						$signed(exp_r.pressure), $signed(exp_r.tenths),
						$signed(exp_r.degrees), exp_r.err, $signed(got.pressure),
						$signed(got.tenths), $signed(got.degrees), got.err);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0, div_error;
	logic [15:0] raw_temp = 0, temp_tenths;
	logic [18:0] raw_pressure = 0;
	logic [31:0] pressure_pa;
	logic [12:0] temp_degrees;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = bsc_pkg::CFG_WORD_A;
	logic [63:0] cfg_data = 0;

	comp_scoreboard board = new();
	bit quiet = 0, hold_long = 0, done = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	baro_sensor_compensation i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic write_cal(bsc_pkg::cfg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			bsc_pkg::CFG_WORD_A: board.word_a = val;
			bsc_pkg::CFG_WORD_B: board.word_b = val;
			bsc_pkg::CFG_WORD_C: board.word_c = {32'd0, val[31:0]};
			default: board.oss = val[1:0];
		endcase
	endtask

	task automatic send_reading(logic [15:0] ut, logic [18:0] up);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temp <= ut;
		raw_pressure <= up;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_reading(ut, up);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic typical_cal(int oss_val);
		write_cal(bsc_pkg::CFG_WORD_A, {16'd32741, 16'hC8C3, 16'hFB93, 16'd408});
		write_cal(bsc_pkg::CFG_WORD_B, {16'd4, 16'd6190, 16'd23153, 16'd32757});
		write_cal(bsc_pkg::CFG_WORD_C, {32'd0, 16'd2868, 16'hD4BD});
		write_cal(bsc_pkg::CFG_OSS, 64'(oss_val));
	endtask

	task automatic random_cal;
		write_cal(bsc_pkg::CFG_WORD_A, {$urandom, $urandom});
		write_cal(bsc_pkg::CFG_WORD_B, {$urandom, $urandom});
		write_cal(bsc_pkg::CFG_WORD_C, {$urandom, $urandom});
		write_cal(bsc_pkg::CFG_OSS, 64'($urandom_range(0, 3)));
	endtask

	// receiver side, with one long hold-off
	always @(posedge clk) begin
		if (hold_long) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
		if (out_valid && !out_stall)
			board.check_result({pressure_pa, temp_tenths, temp_degrees, div_error});
	end

	initial begin
		wait (arst_n);
		while (board.pending.size() < 40) @(posedge clk);
		hold_long = 1;
		repeat (300) @(posedge clk);
		hold_long = 0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000 && !done) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset calibration: divide-by-zero path
		send_reading(16'd27898, 19'd23843);
		send_reading(16'hFFFF, 19'h7FFFF);
		drain();
		typical_cal(0);
		send_reading(16'd27898, 19'd23843);
		send_reading(16'd0, 19'd0);
		send_reading(16'hFFFF, 19'h7FFFF);
		send_reading(16'hAAAA, 19'h55555);
		send_reading(16'h5555, 19'h2AAAA);
		for (int i = 0; i < 400; i++)
			send_reading(16'($urandom), 19'($urandom));
		drain();
		typical_cal(3);
		send_reading(16'd0, 19'h7FFFF);
		send_reading(16'hFFFF, 19'd0);
		drain();
		// ac5 and md both zero make x1 and x3 zero: zero divisor
		write_cal(bsc_pkg::CFG_WORD_B, 64'h0000_0000_0000_0000);
		write_cal(bsc_pkg::CFG_WORD_C, 64'h0000_0000_0000_1234);
		send_reading(16'd100, 19'd1000);
		drain();
		write_cal(bsc_pkg::CFG_WORD_A, 64'h0000_0000_0000_0000);
		write_cal(bsc_pkg::CFG_WORD_C, {32'd0, 16'd2868, 16'hD4BD});
		send_reading(16'd27898, 19'd23843);
		drain();
		write_cal(bsc_pkg::CFG_WORD_A, 64'hFFFF_8000_8000_8000);
		write_cal(bsc_pkg::CFG_WORD_B, 64'h8000_7FFF_FFFF_FFFF);
		write_cal(bsc_pkg::CFG_WORD_C, 64'h0000_0000_8000_7FFF);
		send_reading(16'hFFFF, 19'h7FFFF);
		send_reading(16'd0, 19'd0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 0)
				typical_cal(ph / 2);
			else
				random_cal();
			if (ph == 7)
				quiet = 1;
			for (int i = 0; i < 200; i++)
				send_reading(
					(ph % 2 == 0) ? 16'($urandom_range(20000, 40000)) : 16'($urandom),
					(ph % 2 == 0) ? 19'($urandom_range(10000, 200000)) : 19'($urandom));
			drain();
		end
		done = 1;
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (board.pending.size() > 0 && done == 0 && $time > 64'd200_000_000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

// ===== baro_sensor_compensation.f =====
rtl/bsc_pkg.sv
rtl/bsc_udiv.sv
rtl/baro_sensor_compensation.sv
tb/tb_baro_sensor_compensation.sv
